>>> rtl/pno_pkg.sv
// Package: types, constants and lookup helpers for the octave noise block.
`timescale 1ns / 1ps
package pno_pkg;

   localparam int FRAC_BITS = 16;
   localparam int COORD_W   = 32;
   localparam int AMP_W     = 24;
   localparam int FREQ_W    = 24;
   localparam int PERS_W    = 16;
   localparam int LAC_W     = 20;
   localparam int OCT_W     = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int GRAD_W    = 22;
   localparam int QW        = 24;
   localparam int MUL_A_W   = 33;
   localparam int MUL_B_W   = 25;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SUM_W     = 40;

   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AMPLITUDE   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQUENCY   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERSISTENCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LACUNARITY  = 3'd4;

   localparam logic [OCT_W-1:0]  OCT_RESET  = 4'd4;
   localparam logic [AMP_W-1:0]  AMP_RESET  = 24'd65536;
   localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;
   localparam logic [PERS_W-1:0] PERS_RESET = 16'd32768;
   localparam logic [LAC_W-1:0]  LAC_RESET  = 20'd131072;
   localparam logic [FREQ_W-1:0] FREQ_MAX   = 24'hFFFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   typedef enum logic [4:0] {
      OP_SX, OP_SY, OP_SZ,
      OP_FX0, OP_FX1, OP_FX2, OP_FX3,
      OP_FY0, OP_FY1, OP_FY2, OP_FY3,
      OP_FZ0, OP_FZ1, OP_FZ2, OP_FZ3,
      OP_H0, OP_H1, OP_GRAD,
      OP_LX0, OP_LX1, OP_LX2, OP_LX3,
      OP_LY0, OP_LY1, OP_LZ,
      OP_ACC, OP_AMP, OP_FRQ
   } op_type;

   localparam logic [7:0] PERM [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
      8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
      8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
      8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
      8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
      8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
      8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
      8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
      8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
      8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
      8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
      8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
      8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
      8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
      8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
      8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
      8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
      8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
      8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
      8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
      8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
      8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
   };

   localparam logic [3:0] H_C12 = 4'd12;
   localparam logic [3:0] H_C14 = 4'd14;

   function automatic logic signed [GRAD_W-1:0] grad(
      input logic [3:0] h,
      input logic signed [GRAD_W-1:0] x,
      input logic signed [GRAD_W-1:0] y,
      input logic signed [GRAD_W-1:0] z);
      logic signed [GRAD_W-1:0] u;
      logic signed [GRAD_W-1:0] v;
      u = (h < 4'd8) ? x : y;
      v = (h < 4'd4) ? y : (((h == H_C12) || (h == H_C14)) ? x : z);
      return (h[0] ? -u : u) + (h[1] ? -v : v);
   endfunction

endpackage

>>> rtl/pno_if.sv
// Interfaces: point request channel and noise result channel.
`timescale 1ns / 1ps
interface pno_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] point_x;
   logic [31:0] point_y;
   logic [31:0] point_z;
   modport source (output valid, output point_x, output point_y, output point_z,
                   input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 output ready);
endinterface

interface pno_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] noise_sum;
   modport source (output valid, output noise_sum, input ready);
   modport sink (input valid, input noise_sum, output ready);
endinterface

>>> rtl/pno_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
module pno_mul
   import pno_pkg::*;
(
   input  logic                        clock,
   input  logic signed [MUL_A_W-1:0]   a,
   input  logic signed [MUL_B_W-1:0]   b,
   output logic signed [PROD_W-1:0]    prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

endmodule

>>> rtl/perlin_noise_3d_octaves.sv
// Top level: multi-octave 3D gradient noise over one shared multiplier.
//
// Usage:
//  - req channel: one point (point_x/y/z, signed Q16.16) per transfer. The block
//    takes a point only when idle; while it works req.ready is low.
//  - rsp channel: one noise_sum (signed Q16.16, saturated) per point.
//  - csr port: csr_we, csr_index, csr_wdata; write only while idle.
//  - Each octave is 28 micro-steps on one 33x25 multiplier: 25 multiplies, each
//    with an operand-issue step and a product write-back step, plus 3 hash
//    steps.
//  - A point with zero octaves goes straight to the output stage; otherwise
//    the octaves run one after another before the result is loaded.
//  - The result sits in an output register; a stalled receiver holds the
//    block at the end of the next point until the register frees up.
//  - Reset (synchronous) returns the sequencer to idle, drops rsp.valid and
//    loads the configuration defaults.
`timescale 1ns / 1ps
module perlin_noise_3d_octaves
   import pno_pkg::*;
#(
   parameter int MAX_OCTAVES = 8
)(
   input  logic                   clock,
   input  logic                   reset,
   pno_req_if.sink                req,
   pno_rsp_if.source              rsp,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CW = $clog2(MAX_OCTAVES + 1);
   localparam logic signed [QW-1:0] Q_FIFTEEN = QW'(15 << FRAC_BITS);
   localparam logic signed [QW-1:0] Q_TEN     = QW'(10 << FRAC_BITS);
   localparam logic signed [GRAD_W-1:0] G_ONE = GRAD_W'(1 << FRAC_BITS);

   logic [OCT_W-1:0]  oct_cfg_ff;
   logic [AMP_W-1:0]  amp_cfg_ff;
   logic [FREQ_W-1:0] freq_cfg_ff;
   logic [PERS_W-1:0] pers_cfg_ff;
   logic [LAC_W-1:0]  lac_cfg_ff;

   state_type state_ff, state_in;
   op_type    op_ff;
   logic      phase_ff;
   logic [CW-1:0] oct_left_ff;

   logic signed [COORD_W-1:0] pt_ff [3];
   logic [AMP_W-1:0]  amp_ff;
   logic [FREQ_W-1:0] freq_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [7:0]  cell_ff [3];
   logic [15:0] frac_ff [3];
   logic [15:0] fade_ff [3];
   logic signed [QW-1:0] q_ff;
   logic [7:0] ha_ff, hb_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [GRAD_W-1:0] g_ff [8];
   logic signed [GRAD_W-1:0] lv_ff [4];
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod;

   logic        req_fire, is_mul, step_done, last_op, out_load;
   logic [4:0]  oct_req;
   logic [CW-1:0] oct_n;
   logic [4:0]  fidx;
   logic [1:0]  fax;
   logic [15:0] ft;
   logic signed [QW-1:0] q0;
   logic signed [GRAD_W-1:0] la, lb, ldiff;
   logic [15:0] lt;
   logic [1:0]  ldst;
   logic signed [GRAD_W-1:0] gx0, gy0, gz0, gx1, gy1, gz1;

   pno_mul u_mul (
      .clock   (clock),
      .a       (mul_a),
      .b       (mul_b),
      .prod_ff (prod)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         oct_cfg_ff  <= OCT_RESET;
         amp_cfg_ff  <= AMP_RESET;
         freq_cfg_ff <= FREQ_RESET;
         pers_cfg_ff <= PERS_RESET;
         lac_cfg_ff  <= LAC_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_OCTAVES:     oct_cfg_ff  <= csr_wdata[OCT_W-1:0];
            CSR_AMPLITUDE:   amp_cfg_ff  <= csr_wdata[AMP_W-1:0];
            CSR_FREQUENCY:   freq_cfg_ff <= csr_wdata[FREQ_W-1:0];
            CSR_PERSISTENCE: pers_cfg_ff <= csr_wdata[PERS_W-1:0];
            CSR_LACUNARITY:  lac_cfg_ff  <= csr_wdata[LAC_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_fire = req.valid && req.ready;
   assign oct_req  = {1'b0, oct_cfg_ff};
   assign oct_n    = (oct_req > 5'(MAX_OCTAVES)) ? CW'(MAX_OCTAVES) : CW'(oct_req);
   assign is_mul   = !((op_ff == OP_H0) || (op_ff == OP_H1) || (op_ff == OP_GRAD));
   assign step_done = !is_mul || phase_ff;
   assign last_op  = (op_ff == OP_FRQ) && (oct_left_ff == CW'(1));
   assign out_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (req_fire) state_in = (oct_n == '0) ? ST_FINISH : ST_RUN;
         ST_RUN:    if (step_done && last_op) state_in = ST_FINISH;
         ST_FINISH: if (out_load) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = rsp_valid_ff;
      rsp.noise_sum = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_SX;
         phase_ff     <= 1'b0;
         oct_left_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            op_ff       <= OP_SX;
            phase_ff    <= 1'b0;
            oct_left_ff <= oct_n;
         end else if (state_ff == ST_RUN) begin
            phase_ff <= is_mul && !phase_ff;
            if (step_done) begin
               if (op_ff == OP_FRQ) begin
                  op_ff       <= OP_SX;
                  oct_left_ff <= oct_left_ff - CW'(1);
               end else begin
                  op_ff <= op_type'(op_ff + 5'd1);
               end
            end
         end
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // operand decode
   always_comb begin
      fidx  = 5'(op_ff) - 5'(OP_FX0);
      fax   = fidx[3:2];
      ft    = frac_ff[fax];
      q0    = QW'(signed'({8'b0, ft}) * 6) - Q_FIFTEEN;
      la    = g_ff[0];
      lb    = g_ff[1];
      lt    = fade_ff[0];
      ldst  = 2'd0;
      case (op_ff)
         OP_LX0: begin la = g_ff[0]; lb = g_ff[1]; lt = fade_ff[0]; ldst = 2'd0; end
         OP_LX1: begin la = g_ff[2]; lb = g_ff[3]; lt = fade_ff[0]; ldst = 2'd1; end
         OP_LX2: begin la = g_ff[4]; lb = g_ff[5]; lt = fade_ff[0]; ldst = 2'd2; end
         OP_LX3: begin la = g_ff[6]; lb = g_ff[7]; lt = fade_ff[0]; ldst = 2'd3; end
         OP_LY0: begin la = lv_ff[0]; lb = lv_ff[1]; lt = fade_ff[1]; ldst = 2'd0; end
         OP_LY1: begin la = lv_ff[2]; lb = lv_ff[3]; lt = fade_ff[1]; ldst = 2'd1; end
         OP_LZ:  begin la = lv_ff[0]; lb = lv_ff[1]; lt = fade_ff[2]; ldst = 2'd0; end
         default: ;
      endcase
      ldiff = lb - la;

      mul_a = '0;
      mul_b = '0;
      case (op_ff) inside
         OP_SX: begin mul_a = MUL_A_W'(pt_ff[0]); mul_b = {1'b0, freq_ff}; end
         OP_SY: begin mul_a = MUL_A_W'(pt_ff[1]); mul_b = {1'b0, freq_ff}; end
         OP_SZ: begin mul_a = MUL_A_W'(pt_ff[2]); mul_b = {1'b0, freq_ff}; end
         OP_FX0, OP_FY0, OP_FZ0: begin
            mul_a = MUL_A_W'(q0);
            mul_b = {9'b0, ft};
         end
         OP_FX1, OP_FX2, OP_FX3, OP_FY1, OP_FY2, OP_FY3, OP_FZ1, OP_FZ2, OP_FZ3: begin
            mul_a = MUL_A_W'(q_ff);
            mul_b = {9'b0, ft};
         end
         OP_LX0, OP_LX1, OP_LX2, OP_LX3, OP_LY0, OP_LY1, OP_LZ: begin
            mul_a = MUL_A_W'(ldiff);
            mul_b = {9'b0, lt};
         end
         OP_ACC: begin mul_a = MUL_A_W'(lv_ff[0]); mul_b = {1'b0, amp_ff}; end
         OP_AMP: begin mul_a = {17'b0, pers_cfg_ff}; mul_b = {1'b0, amp_ff}; end
         OP_FRQ: begin mul_a = {13'b0, lac_cfg_ff}; mul_b = {1'b0, freq_ff}; end
         default: ;
      endcase

      gx0 = signed'({6'b0, frac_ff[0]});
      gy0 = signed'({6'b0, frac_ff[1]});
      gz0 = signed'({6'b0, frac_ff[2]});
      gx1 = gx0 - G_ONE;
      gy1 = gy0 - G_ONE;
      gz1 = gz0 - G_ONE;
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         pt_ff[0] <= signed'(req.point_x);
         pt_ff[1] <= signed'(req.point_y);
         pt_ff[2] <= signed'(req.point_z);
         amp_ff   <= amp_cfg_ff;
         freq_ff  <= freq_cfg_ff;
         sum_ff   <= '0;
      end else if (state_ff == ST_RUN) begin
         case (op_ff)
            OP_H0: begin
               ha_ff <= PERM[cell_ff[0]] + cell_ff[1];
               hb_ff <= PERM[cell_ff[0] + 8'd1] + cell_ff[1];
            end
            OP_H1: begin
               aa_ff <= PERM[ha_ff] + cell_ff[2];
               ab_ff <= PERM[ha_ff + 8'd1] + cell_ff[2];
               ba_ff <= PERM[hb_ff] + cell_ff[2];
               bb_ff <= PERM[hb_ff + 8'd1] + cell_ff[2];
            end
            OP_GRAD: begin
               g_ff[0] <= grad(PERM[aa_ff][3:0], gx0, gy0, gz0);
               g_ff[1] <= grad(PERM[ba_ff][3:0], gx1, gy0, gz0);
               g_ff[2] <= grad(PERM[ab_ff][3:0], gx0, gy1, gz0);
               g_ff[3] <= grad(PERM[bb_ff][3:0], gx1, gy1, gz0);
               g_ff[4] <= grad(PERM[aa_ff + 8'd1][3:0], gx0, gy0, gz1);
               g_ff[5] <= grad(PERM[ba_ff + 8'd1][3:0], gx1, gy0, gz1);
               g_ff[6] <= grad(PERM[ab_ff + 8'd1][3:0], gx0, gy1, gz1);
               g_ff[7] <= grad(PERM[bb_ff + 8'd1][3:0], gx1, gy1, gz1);
            end
            default: begin
               if (phase_ff) begin
                  case (op_ff) inside
                     OP_SX, OP_SY, OP_SZ: begin
                        cell_ff[fidx[1:0] + 2'd3] <= prod[39:32];
                        frac_ff[fidx[1:0] + 2'd3] <= prod[31:16];
                     end
                     OP_FX0, OP_FY0, OP_FZ0: q_ff <= signed'(prod[39:16]) + Q_TEN;
                     OP_FX1, OP_FX2, OP_FY1, OP_FY2, OP_FZ1, OP_FZ2:
                        q_ff <= signed'(prod[39:16]);
                     OP_FX3, OP_FY3, OP_FZ3: fade_ff[fax] <= prod[31:16];
                     OP_LX0, OP_LX1, OP_LX2, OP_LX3, OP_LY0, OP_LY1, OP_LZ:
                        lv_ff[ldst] <= la + signed'(prod[37:16]);
                     OP_ACC: sum_ff <= sum_ff + signed'(prod[55:16]);
                     OP_AMP: amp_ff <= prod[39:16];
                     OP_FRQ: freq_ff <= (prod[57:40] != '0) ? FREQ_MAX : prod[39:16];
                     default: ;
                  endcase
               end
            end
         endcase
      end
   end

   // saturated result
   always_ff @(posedge clock) begin
      if (out_load) begin
         if (sum_ff > SUM_W'(signed'(32'h7FFFFFFF)))
            rsp_data_ff <= 32'h7FFFFFFF;
         else if (sum_ff < SUM_W'(signed'(32'h80000000)))
            rsp_data_ff <= 32'h80000000;
         else
            rsp_data_ff <= sum_ff[31:0];
      end
   end

endmodule

>>> rtl/pno_check.sv
// Port checker for the octave noise block, bound to the top level.
`timescale 1ns / 1ps
module pno_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] noise_sum
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready while a point is in work");

   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("result appeared one cycle after request transfer");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(noise_sum)))
      else $error("stalled result changed");

endmodule

bind perlin_noise_3d_octaves pno_check u_pno_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .noise_sum (rsp.noise_sum)
);
